>>> src/dsc_pkg.sv
// shared constants and types for the distinct subsequence counter
`default_nettype none
package dsc_pkg;

  // capacity and arithmetic width
  localparam int PATTERN_MAX = 64;
  localparam int COUNT_BITS  = 32;

  // field widths fixed by the item formats
  localparam int CMD_BITS   = 1;
  localparam int POS_BITS   = 6;
  localparam int CHAR_BITS  = 8;
  localparam int CFG_BITS   = 7;
  localparam int OUT_BITS   = 32;

  // derived widths
  localparam int LEN_BITS   = $clog2(PATTERN_MAX + 1);
  localparam int SLOT_BITS  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = (PATTERN_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_LOAD   = 1'b0;
  localparam logic [CMD_BITS-1:0] CMD_STREAM = 1'b1;

  // control broadcast to every cell
  typedef struct packed {
    logic                 clear;
    logic                 load;
    logic                 update;
    logic [POS_BITS-1:0]  position;
    logic [CHAR_BITS-1:0] ch;
    logic [LEN_BITS-1:0]  len;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> src/dsc_if.sv
// item channels and the configuration write channel
`default_nettype none
interface dsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [dsc_pkg::CMD_BITS-1:0]  cmd;
  logic [dsc_pkg::POS_BITS-1:0]  position;
  logic [dsc_pkg::CHAR_BITS-1:0] char_value;
  logic                          last;

  modport source (output valid, cmd, position, char_value, last, input ready);
  modport sink   (input valid, cmd, position, char_value, last, output ready);
endinterface

interface dsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dsc_pkg::OUT_BITS-1:0] subseq_count;
  logic                         saturated;
  logic                         last_out;

  modport source (output valid, subseq_count, saturated, last_out, input ready);
  modport sink   (input valid, subseq_count, saturated, last_out, output ready);
endinterface

interface dsc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dsc_pkg::CFG_BITS-1:0] pattern_length;

  modport source (output valid, pattern_length, input ready);
  modport sink   (input valid, pattern_length, output ready);
endinterface
`default_nettype wire

>>> src/dsc_cell.sv
// one pattern position: pattern byte, count entry and sticky saturation flag
`default_nettype none
module dsc_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [dsc_pkg::SLOT_BITS-1:0]    slot,
  input  wire dsc_pkg::cell_ctl_t               ctl,
  input  wire logic [dsc_pkg::COUNT_BITS-1:0]   prev_count,
  output logic      [dsc_pkg::COUNT_BITS-1:0]   count,
  output logic      [dsc_pkg::COUNT_BITS-1:0]   tap,
  output logic                                  sat
);

  logic [dsc_pkg::CHAR_BITS-1:0]  pattern;
  logic [dsc_pkg::COUNT_BITS:0]   sum;
  logic [dsc_pkg::LEN_BITS-1:0]   entry;
  logic                           active;
  logic                           hit;

  // this cell holds row entry slot + 1
  assign entry  = dsc_pkg::LEN_BITS'(slot) + dsc_pkg::LEN_BITS'(1);
  assign active = entry <= ctl.len;
  assign hit    = ctl.update && active && (pattern == ctl.ch);
  assign sum    = {1'b0, count} + {1'b0, prev_count};
  assign tap    = (entry == ctl.len) ? count : '0;

  // pattern byte, written by a load item aimed at this slot
  always_ff @(posedge clk) begin
    if (ctl.load && (int'(ctl.position) == int'(slot))) begin
      pattern <= ctl.ch;
    end
  end

  // count entry with saturating add of the left neighbor's old value
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
      sat   <= 1'b0;
    end else if (hit) begin
      if (sum[dsc_pkg::COUNT_BITS]) begin
        count <= dsc_pkg::COUNT_MAX;
        sat   <= 1'b1;
      end else begin
        count <= sum[dsc_pkg::COUNT_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> src/dsc_gather.sv
// two-level or tree that picks the tail entry and any saturation flag
`default_nettype none
module dsc_gather (
  input  wire logic                           clk,
  input  wire logic                           capture,
  input  wire logic [dsc_pkg::COUNT_BITS-1:0] taps [dsc_pkg::PATTERN_MAX],
  input  wire logic                           sats [dsc_pkg::PATTERN_MAX],
  output logic      [dsc_pkg::COUNT_BITS-1:0] count_or,
  output logic                                sat_or
);

  logic [dsc_pkg::COUNT_BITS-1:0] group_count [dsc_pkg::GROUPS];
  logic                           group_sat   [dsc_pkg::GROUPS];
  logic [dsc_pkg::COUNT_BITS-1:0] group_count_next [dsc_pkg::GROUPS];
  logic                           group_sat_next   [dsc_pkg::GROUPS];

  // first level: or within each group of cells
  always_comb begin
    for (int g = 0; g < dsc_pkg::GROUPS; g++) begin
      group_count_next[g] = '0;
      group_sat_next[g]   = 1'b0;
      for (int i = 0; i < dsc_pkg::GROUP_SIZE; i++) begin
        if (g * dsc_pkg::GROUP_SIZE + i < dsc_pkg::PATTERN_MAX) begin
          group_count_next[g] = group_count_next[g] | taps[g * dsc_pkg::GROUP_SIZE + i];
          group_sat_next[g]   = group_sat_next[g] | sats[g * dsc_pkg::GROUP_SIZE + i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      group_count <= group_count_next;
      group_sat   <= group_sat_next;
    end
  end

  // second level: or across the group registers
  always_comb begin
    count_or = '0;
    sat_or   = 1'b0;
    for (int g = 0; g < dsc_pkg::GROUPS; g++) begin
      count_or = count_or | group_count[g];
      sat_or   = sat_or | group_sat[g];
    end
  end

endmodule
`default_nettype wire

>>> src/distinct_subsequence_counter.sv
// top level: cell chain, result gather and item sequencing
//
// Counts the ways a loaded pattern (up to 64 bytes, set by pattern_length)
// occurs as a subsequence of a streamed text. A load item (cmd 0) writes one
// pattern byte and clears the count row; it leaves the sequencer idle and
// gives no result. A text item (cmd 1) updates every cell of the chain in the
// cycle it is accepted, then the tail entry is gathered through a two-level
// registered or tree, and the next item is taken only once the text item has
// passed the gather and emit states, later while the output register still
// holds a result that has not been accepted; its result then waits in the
// output register while the next item proceeds. Counts saturate at the 32-bit
// maximum and set saturated until the row is cleared by a load item or after
// a text item marked last. Configuration writes are always taken and are
// meant for idle periods.
`default_nettype none
module distinct_subsequence_counter (
  input wire logic   clk,
  input wire logic   rst,
  dsc_in_if.sink     items_in,
  dsc_out_if.source  results,
  dsc_cfg_if.sink    cfg
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_EMIT
  } state_t;

  state_t                          state;
  logic [dsc_pkg::CFG_BITS-1:0]    pattern_length;
  logic [dsc_pkg::LEN_BITS-1:0]    len_eff;
  logic                            item_last;
  logic                            accept;
  logic                            out_free;
  dsc_pkg::cell_ctl_t              ctl;

  logic [dsc_pkg::COUNT_BITS-1:0]  counts [dsc_pkg::PATTERN_MAX];
  logic [dsc_pkg::COUNT_BITS-1:0]  taps   [dsc_pkg::PATTERN_MAX];
  logic                            sats   [dsc_pkg::PATTERN_MAX];
  logic [dsc_pkg::COUNT_BITS-1:0]  count_or;
  logic                            sat_or;
  logic [dsc_pkg::COUNT_BITS-1:0]  final_count;

  logic                            out_valid;
  logic [dsc_pkg::OUT_BITS-1:0]    out_count;
  logic                            out_sat;
  logic                            out_last;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg.valid) begin
      pattern_length <= cfg.pattern_length;
    end
  end

  // lengths above capacity act as full capacity
  assign len_eff = (int'(pattern_length) > dsc_pkg::PATTERN_MAX)
                 ? dsc_pkg::LEN_BITS'(dsc_pkg::PATTERN_MAX)
                 : dsc_pkg::LEN_BITS'(pattern_length);

  // handshake
  assign items_in.ready = (state == ST_IDLE);
  assign accept         = items_in.valid && items_in.ready;
  assign out_free       = !out_valid || results.ready;

  // control broadcast to the chain
  always_comb begin
    ctl.load     = accept && (items_in.cmd == dsc_pkg::CMD_LOAD);
    ctl.update   = accept && (items_in.cmd == dsc_pkg::CMD_STREAM);
    ctl.clear    = ctl.load || ((state == ST_GATHER) && item_last);
    ctl.position = items_in.position;
    ctl.ch       = items_in.char_value;
    ctl.len      = len_eff;
  end

  // chain of cells; entry zero is the constant one
  for (genvar k = 0; k < dsc_pkg::PATTERN_MAX; k++) begin : g_cell
    dsc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .slot       (dsc_pkg::SLOT_BITS'(k)),
      .ctl        (ctl),
      .prev_count ((k == 0) ? dsc_pkg::COUNT_ONE : counts[(k == 0) ? 0 : k - 1]),
      .count      (counts[k]),
      .tap        (taps[k]),
      .sat        (sats[k])
    );
  end

  dsc_gather u_gather (
    .clk      (clk),
    .capture  (state == ST_GATHER),
    .taps     (taps),
    .sats     (sats),
    .count_or (count_or),
    .sat_or   (sat_or)
  );

  // an empty pattern always counts one
  assign final_count = (len_eff == '0) ? dsc_pkg::COUNT_ONE : count_or;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      item_last <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (ctl.update) begin
            item_last <= items_in.last;
            state     <= ST_GATHER;
          end
        end
        ST_GATHER: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_count <= dsc_pkg::OUT_BITS'(final_count);
            out_sat   <= sat_or || (final_count == dsc_pkg::COUNT_MAX);
            out_last  <= item_last;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign results.valid        = out_valid;
  assign results.subseq_count = out_count;
  assign results.saturated    = out_sat;
  assign results.last_out     = out_last;

`ifndef SYNTH
  // a new result only appears from the emit state
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit state");

  // load items never occupy the sequencer
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> state == ST_IDLE)
    else $error("load item left the sequencer busy");

  // a text item runs gather then emit
  a_text_flow: assert property (@(posedge clk) disable iff (rst)
    ctl.update |=> state == ST_GATHER ##1 state == ST_EMIT)
    else $error("text item skipped a stage");

  // a count at the maximum is always flagged
  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count == '1) |-> out_sat)
    else $error("maximum count not flagged as saturated");
`endif

endmodule
`default_nettype wire

>>> tb/distinct_subsequence_counter_test.sv
// testbench for the distinct subsequence counter: predicted counts checked per item
`timescale 1ns / 100ps
module distinct_subsequence_counter_test;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int TIMEOUT_NS    = 8_000_000;
  localparam int LEN_FIELD_MAX = (1 << dsc_pkg::CFG_BITS) - 1;

  typedef struct packed {
    logic [dsc_pkg::OUT_BITS-1:0] subseq_count;
    logic                         saturated;
    logic                         last_out;
  } count_result_t;

  typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

  logic clk;
  logic rst;

  dsc_in_if  items_ch ();
  dsc_out_if results_ch ();
  dsc_cfg_if cfg_ch ();

  distinct_subsequence_counter uut (
    .clk      (clk),
    .rst      (rst),
    .items_in (items_ch),
    .results  (results_ch),
    .cfg      (cfg_ch)
  );

  // predicted state of the counter
  logic [dsc_pkg::CHAR_BITS-1:0]  pattern_bytes [dsc_pkg::PATTERN_MAX];
  bit                             pattern_known [dsc_pkg::PATTERN_MAX];
  logic [dsc_pkg::COUNT_BITS-1:0] ways_row [0:dsc_pkg::PATTERN_MAX];
  bit                             ways_saturated;
  int unsigned                    pattern_len;

  count_result_t expected_counts [$];
  int unsigned   mismatches;
  int unsigned   items_sent;
  int unsigned   burst_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void clear_ways();
    for (int j = 0; j <= dsc_pkg::PATTERN_MAX; j++) ways_row[j] = '0;
    ways_row[0] = dsc_pkg::COUNT_ONE;
    ways_saturated = 1'b0;
  endfunction

  function automatic void store_pattern_byte(input logic [dsc_pkg::POS_BITS-1:0] pos,
                                             input logic [dsc_pkg::CHAR_BITS-1:0] ch);
    pattern_bytes[pos] = ch;
    pattern_known[pos] = 1'b1;
    clear_ways();
  endfunction

  // one text byte: update the row top down so each entry adds the old one below
  function automatic count_result_t advance_ways(input logic [dsc_pkg::CHAR_BITS-1:0] ch,
                                                 input logic lst);
    int unsigned                  span;
    logic [dsc_pkg::COUNT_BITS:0] sum;
    count_result_t                r;
    span = (pattern_len > dsc_pkg::PATTERN_MAX) ? dsc_pkg::PATTERN_MAX : pattern_len;
    for (int j = int'(span); j >= 1; j--) begin
      if (pattern_bytes[j-1] == ch) begin
        sum = {1'b0, ways_row[j]} + {1'b0, ways_row[j-1]};
        if (sum[dsc_pkg::COUNT_BITS]) begin
          ways_row[j] = dsc_pkg::COUNT_MAX;
          ways_saturated = 1'b1;
        end else begin
          ways_row[j] = sum[dsc_pkg::COUNT_BITS-1:0];
        end
      end
    end
    r.subseq_count = dsc_pkg::OUT_BITS'(ways_row[span]);
    r.saturated    = ways_saturated || (ways_row[span] == dsc_pkg::COUNT_MAX);
    r.last_out     = lst;
    if (lst) clear_ways();
    return r;
  endfunction

  function automatic bit prefix_known(input int unsigned span);
    for (int i = 0; i < span; i++) begin
      if (!pattern_known[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // result receiver: ready follows a mode that changes now and then
  initial begin
    sink_mode_t mode;
    int unsigned mode_left;
    mode = SINK_OPEN;
    mode_left = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      case (mode)
        SINK_OPEN: begin
          results_ch.ready <= 1'b1;
        end
        SINK_CHOPPY: begin
          results_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          results_ch.ready <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    count_result_t want;
    if (!rst && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
      if (expected_counts.size() == 0) begin
        note_error($sformatf("unexpected result: count %0d saturated %0b last %0b",
                             results_ch.subseq_count, results_ch.saturated,
                             results_ch.last_out));
      end else begin
        want = expected_counts.pop_front();
        if (results_ch.subseq_count !== want.subseq_count)
          note_error($sformatf("subseq_count mismatch: expected %0d, got %0d",
                               want.subseq_count, results_ch.subseq_count));
        if (results_ch.saturated !== want.saturated)
          note_error($sformatf("saturated mismatch: expected %0b, got %0b",
                               want.saturated, results_ch.saturated));
        if (results_ch.last_out !== want.last_out)
          note_error($sformatf("last_out mismatch: expected %0b, got %0b",
                               want.last_out, results_ch.last_out));
      end
    end
  end

  // send one item, in bursts with idle gaps between them
  task automatic send_item(input logic [dsc_pkg::CMD_BITS-1:0] cmd,
                           input logic [dsc_pkg::POS_BITS-1:0] pos,
                           input logic [dsc_pkg::CHAR_BITS-1:0] ch,
                           input logic lst);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(1, 8);
    end
    items_ch.valid      <= 1'b1;
    items_ch.cmd        <= cmd;
    items_ch.position   <= pos;
    items_ch.char_value <= ch;
    items_ch.last       <= lst;
    do @(posedge clk); while (items_ch.ready !== 1'b1);
    if (cmd == dsc_pkg::CMD_LOAD) store_pattern_byte(pos, ch);
    else expected_counts.push_back(advance_ways(ch, lst));
    items_sent++;
    burst_left--;
    if (burst_left == 0) items_ch.valid <= 1'b0;
  endtask

  task automatic stop_items();
    if (burst_left != 0) begin
      items_ch.valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic wait_idle();
    stop_items();
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic set_pattern_length(input int unsigned len);
    wait_idle();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.pattern_length <= dsc_pkg::CFG_BITS'(len);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    pattern_len = len;
  endtask

  task automatic send_text(input logic [dsc_pkg::CHAR_BITS-1:0] ch, input logic lst);
    send_item(dsc_pkg::CMD_STREAM,
              dsc_pkg::POS_BITS'($urandom_range(0, dsc_pkg::PATTERN_MAX - 1)), ch, lst);
  endtask

  // length zero: every text byte counts one
  task automatic test_empty_pattern();
    send_item(dsc_pkg::CMD_STREAM, '0, 8'h00, 1'b0);
    send_item(dsc_pkg::CMD_STREAM, '1, 8'hFF, 1'b1);
  endtask

  // short pattern with extreme bytes, last flag on a load, top position
  task automatic test_short_pattern();
    set_pattern_length(3);
    send_item(dsc_pkg::CMD_LOAD, 6'd0, 8'h00, 1'b0);
    send_item(dsc_pkg::CMD_LOAD, 6'd1, 8'hFF, 1'b0);
    send_item(dsc_pkg::CMD_LOAD, 6'd2, 8'h00, 1'b0);
    send_item(dsc_pkg::CMD_LOAD, 6'd63, 8'hFF, 1'b1);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);
  endtask

  // length changed in the middle of a text, entries above keep their values
  task automatic test_length_change();
    set_pattern_length(2);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    set_pattern_length(3);
    send_text(8'h00, 1'b0);
    set_pattern_length(1);
    send_text(8'h00, 1'b1);
    set_pattern_length(0);
    send_text(8'hAA, 1'b1);
  endtask

  // one repeated byte in pattern and text drives the count to the top
  task automatic run_saturating_text();
    int unsigned len;
    int unsigned guard;
    logic [dsc_pkg::CHAR_BITS-1:0] ch;
    len = $urandom_range(10, 16);
    ch = dsc_pkg::CHAR_BITS'($urandom_range(0, 255));
    set_pattern_length(len);
    for (int i = 0; i < len; i++)
      send_item(dsc_pkg::CMD_LOAD, dsc_pkg::POS_BITS'(i), ch, 1'b0);
    guard = 0;
    while (ways_row[len] != dsc_pkg::COUNT_MAX && guard < 100) begin
      send_text(ch, 1'b0);
      guard++;
    end
    send_text(ch, 1'b0);
    send_text(ch ^ 8'h01, 1'b0);
    send_text(ch, 1'b1);
  endtask

  task automatic test_saturation();
    run_saturating_text();
  endtask

  // random phases: a length, a pattern from a small alphabet, several texts
  task automatic test_random_phases();
    int unsigned start;
    int unsigned phase;
    int unsigned pick;
    int unsigned len;
    int unsigned span;
    int unsigned texts;
    int unsigned tlen;
    int unsigned alpha_n;
    logic [dsc_pkg::CHAR_BITS-1:0] alpha [4];
    logic [dsc_pkg::CHAR_BITS-1:0] ch;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (phase == 0) begin
        len = dsc_pkg::PATTERN_MAX;
      end else if (phase == 1) begin
        len = LEN_FIELD_MAX;
      end else if (pick < 6) begin
        run_saturating_text();
        phase++;
        continue;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 0;
        else if (pick < 65) len = $urandom_range(1, 6);
        else if (pick < 85) len = $urandom_range(7, 20);
        else if (pick < 93) len = dsc_pkg::PATTERN_MAX;
        else len = $urandom_range(dsc_pkg::PATTERN_MAX + 1, LEN_FIELD_MAX);
      end
      alpha_n = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) alpha[i] = dsc_pkg::CHAR_BITS'($urandom_range(0, 255));
      set_pattern_length(len);
      span = (len > dsc_pkg::PATTERN_MAX) ? dsc_pkg::PATTERN_MAX : len;

      // well-formed pattern load, sometimes kept from before
      if (!prefix_known(span) || $urandom_range(0, 9) < 8) begin
        for (int i = 0; i < span; i++)
          send_item(dsc_pkg::CMD_LOAD, dsc_pkg::POS_BITS'(i),
                    alpha[$urandom_range(0, alpha_n - 1)],
                    ($urandom_range(0, 9) == 0));
      end

      // texts, with an occasional stray load breaking one up
      texts = $urandom_range(1, 4);
      for (int t = 0; t < texts; t++) begin
        tlen = $urandom_range(1, (span + 6 > 40) ? 40 : span + 6);
        for (int k = 0; k < tlen; k++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(dsc_pkg::CMD_LOAD,
                      dsc_pkg::POS_BITS'($urandom_range(0, dsc_pkg::PATTERN_MAX - 1)),
                      dsc_pkg::CHAR_BITS'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          ch = ($urandom_range(0, 9) == 0) ? dsc_pkg::CHAR_BITS'($urandom_range(0, 255))
                                           : alpha[$urandom_range(0, alpha_n - 1)];
          send_text(ch, (k == tlen - 1) && ($urandom_range(0, 5) != 0));
        end
      end
      phase++;
    end
  endtask

  // stimulus and end of run
  initial begin
    rst = 1'b1;
    items_ch.valid = 1'b0;
    items_ch.cmd = dsc_pkg::CMD_LOAD;
    items_ch.position = '0;
    items_ch.char_value = '0;
    items_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.pattern_length = '0;
    for (int i = 0; i < dsc_pkg::PATTERN_MAX; i++) begin
      pattern_bytes[i] = '0;
      pattern_known[i] = 1'b0;
    end
    clear_ways();
    pattern_len = 0;
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_short_pattern();
    test_length_change();
    test_saturation();
    test_random_phases();

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
